/* sv/mapi_pkg.sv */
// types and constants shared by the pose interpolator modules
// no dependencies
`default_nettype none

package mapi_pkg;

  localparam int NumJoints = 4;
  localparam int AngleW    = 16;
  localparam int IdxW      = 6;
  localparam int AccW      = AngleW + IdxW;

  localparam logic [AngleW-1:0] StepSizeReset = 16'd100;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_MAX,
    FS_COUNT,
    FS_DIV,
    FS_PUSH
  } front_state_e;

  // one planned motion handed from the front to the back
  typedef struct packed {
    logic [NumJoints-1:0][AngleW-1:0] start;
    logic [NumJoints-1:0][AngleW-1:0] change;
    logic [NumJoints-1:0]             dir;
    logic [IdxW-1:0]                  steps;
    logic [AngleW-1:0]                quot;
    logic [IdxW:0]                    rem2;
  } mapi_desc_t;

endpackage

`default_nettype wire

/* sv/mapi_front.sv */
// front end: takes a request, finds joint changes, step count and per-step advance
// depends on mapi_pkg
`default_nettype none

module mapi_front
  import mapi_pkg::*;
#(
  parameter int MAX_STEPS = 63
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [AngleW-1:0]                cfg_step_size_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [NumJoints-1:0][AngleW-1:0] start_i,
  input  wire logic [NumJoints-1:0][AngleW-1:0] end_i,
  output logic                                  desc_valid_o,
  input  wire logic                             desc_ready_i,
  output mapi_desc_t                            desc_o
);

  localparam logic [IdxW-1:0] MaxSteps = IdxW'(MAX_STEPS);
  localparam logic [3:0]      LastBit  = 4'(AngleW - 1);

  front_state_e state_q, state_d;

  logic [AngleW-1:0]                step_size_q;
  logic [NumJoints-1:0][AngleW-1:0] start_q;
  logic [NumJoints-1:0][AngleW-1:0] change_q;
  logic [NumJoints-1:0]             dir_q;
  logic [AngleW-1:0]                largest_q;
  logic [AccW-1:0]                  acc_q;
  logic [IdxW-1:0]                  cnt_q;
  logic [IdxW-1:0]                  steps_q;
  logic [AngleW-1:0]                dvd_q;
  logic [IdxW-1:0]                  rem_q;
  logic [3:0]                       bit_q;

  logic                             accept;
  logic [NumJoints-1:0][AngleW:0]   diff;
  logic [NumJoints-1:0][AngleW:0]   diff_neg;
  logic [AngleW-1:0]                largest;
  logic [AngleW-1:0]                divisor;
  logic                             count_more;
  logic [IdxW:0]                    trial;
  logic                             trial_ge;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    for (int j = 0; j < NumJoints; j++) begin
      diff[j]     = {end_i[j][AngleW-1], end_i[j]} - {start_i[j][AngleW-1], start_i[j]};
      diff_neg[j] = (AngleW+1)'(0) - diff[j];
    end
  end

  always_comb begin
    largest = change_q[0];
    for (int j = 1; j < NumJoints; j++) begin
      if (change_q[j] > largest) begin
        largest = change_q[j];
      end
    end
  end

  assign divisor    = (step_size_q == '0) ? AngleW'(1) : step_size_q;
  assign count_more = (acc_q < {{IdxW{1'b0}}, largest_q}) && (cnt_q < MaxSteps);
  assign trial      = {rem_q, dvd_q[AngleW-1]};
  assign trial_ge   = trial >= {1'b0, steps_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FS_IDLE:  if (accept) state_d = FS_MAX;
      FS_MAX:   state_d = FS_COUNT;
      FS_COUNT: if (!count_more) state_d = FS_DIV;
      FS_DIV:   if (bit_q == LastBit) state_d = FS_PUSH;
      FS_PUSH:  if (desc_ready_i) state_d = FS_IDLE;
      default:  state_d = FS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o   = 1'b1;
    desc_valid_o = 1'b0;
    case (state_q)
      FS_IDLE: in_stall_o   = 1'b0;
      FS_PUSH: desc_valid_o = 1'b1;
      default: begin
        in_stall_o   = 1'b1;
        desc_valid_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    desc_o.start  = start_q;
    desc_o.change = change_q;
    desc_o.dir    = dir_q;
    desc_o.steps  = steps_q;
    desc_o.quot   = dvd_q;
    desc_o.rem2   = {rem_q, 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FS_IDLE;
      step_size_q <= StepSizeReset;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        step_size_q <= cfg_step_size_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      FS_IDLE: begin
        if (accept) begin
          for (int j = 0; j < NumJoints; j++) begin
            start_q[j]  <= start_i[j];
            dir_q[j]    <= diff[j][AngleW];
            change_q[j] <= diff[j][AngleW] ? diff_neg[j][AngleW-1:0] : diff[j][AngleW-1:0];
          end
        end
      end
      FS_MAX: begin
        largest_q <= largest;
        acc_q     <= '0;
        cnt_q     <= '0;
      end
      FS_COUNT: begin
        if (count_more) begin
          acc_q <= acc_q + {{IdxW{1'b0}}, divisor};
          cnt_q <= cnt_q + IdxW'(1);
        end else begin
          steps_q <= (cnt_q == '0) ? IdxW'(1) : cnt_q;
          dvd_q   <= largest_q;
          rem_q   <= '0;
          bit_q   <= '0;
        end
      end
      FS_DIV: begin
        rem_q <= trial_ge ? IdxW'(trial - {1'b0, steps_q}) : trial[IdxW-1:0];
        dvd_q <= {dvd_q[AngleW-2:0], trial_ge};
        bit_q <= bit_q + 4'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/mapi_queue.sv */
// two-entry queue of planned motions between front and back
// depends on mapi_pkg
`default_nettype none

module mapi_queue
  import mapi_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        wr_valid_i,
  output logic             wr_ready_o,
  input  wire mapi_desc_t  wr_data_i,
  output logic             rd_valid_o,
  input  wire logic        rd_ready_i,
  output mapi_desc_t       rd_data_o
);

  mapi_desc_t mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       push;
  logic       pop;

  assign wr_ready_o = count_q != 2'd2;
  assign rd_valid_o = count_q != 2'd0;
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/mapi_back.sv */
// back end: walks one planned motion and emits a pose per cycle while the output is not stalled
// depends on mapi_pkg
`default_nettype none

module mapi_back
  import mapi_pkg::*;
(
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             desc_valid_i,
  output logic                                  desc_ready_o,
  input  wire mapi_desc_t                       desc_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [NumJoints-1:0][AngleW-1:0]      pose_o,
  output logic [IdxW-1:0]                       pose_index_o,
  output logic                                  last_pose_o
);

  mapi_desc_t                       desc_q;
  logic                             active_q;
  logic [IdxW-1:0]                  idx_q;
  logic [AngleW-1:0]                adv_q;
  logic [IdxW:0]                    rem_q;
  logic                             out_valid_q;
  logic [NumJoints-1:0][AngleW-1:0] pose_q;
  logic [IdxW-1:0]                  index_q;
  logic                             last_q;

  logic                             load_out;
  logic                             is_last;
  logic [IdxW:0]                    two_steps;
  logic [IdxW+1:0]                  rem_sum;
  logic                             rem_wrap;
  logic [NumJoints-1:0][AngleW-1:0] off;
  logic [NumJoints-1:0][AngleW-1:0] pose;

  assign desc_ready_o = !active_q;
  assign load_out     = active_q && (!out_valid_q || !out_stall_i);
  assign is_last      = idx_q == desc_q.steps;
  assign two_steps    = {desc_q.steps, 1'b0};
  assign rem_sum      = {1'b0, rem_q} + {1'b0, desc_q.rem2};
  assign rem_wrap     = rem_sum >= {1'b0, two_steps};

  always_comb begin
    for (int j = 0; j < NumJoints; j++) begin
      off[j]  = (adv_q < desc_q.change[j]) ? adv_q : desc_q.change[j];
      pose[j] = desc_q.dir[j] ? desc_q.start[j] - off[j] : desc_q.start[j] + off[j];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pose_o       = pose_q;
  assign pose_index_o = index_q;
  assign last_pose_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (!active_q) begin
        active_q <= desc_valid_i;
      end else if (load_out && is_last) begin
        active_q <= 1'b0;
      end
    end
  end

  // running quotient and remainder of (2*i*largest + steps) / (2*steps)
  always_ff @(posedge clk_i) begin
    if (!active_q) begin
      if (desc_valid_i) begin
        desc_q <= desc_i;
        idx_q  <= '0;
        adv_q  <= '0;
        rem_q  <= {1'b0, desc_i.steps};
      end
    end else if (load_out) begin
      idx_q <= idx_q + IdxW'(1);
      if (rem_wrap) begin
        rem_q <= (IdxW+1)'(rem_sum - {1'b0, two_steps});
        adv_q <= adv_q + desc_q.quot + AngleW'(1);
      end else begin
        rem_q <= rem_sum[IdxW:0];
        adv_q <= adv_q + desc_q.quot;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      pose_q  <= pose;
      index_q <= idx_q;
      last_q  <= is_last;
    end
  end

endmodule

`default_nettype wire

/* sv/multi_axis_pose_interpolator.sv */
// top level of the multi-axis pose interpolator: front, queue and back
// depends on mapi_pkg, mapi_front, mapi_queue, mapi_back
`default_nettype none

// Each request carries a start and an end pose of four joints in signed
// centidegrees and yields steps+1 poses, steps being ceil(largest change /
// step_size), at least 1 and at most MAX_STEPS. The front end holds the input
// stalled while it plans a request: it takes the request, finds the largest
// change, counts steps in a repeated-add step counter, divides in a bit-serial
// divider and hands the plan to a two-entry queue, waiting while the queue is
// full. The back end loads a plan and then emits one pose per cycle while the
// output is not stalled, and overlaps with the planning of the next request.
// step_size resets to 100; a value of zero acts as one.

module multi_axis_pose_interpolator
  import mapi_pkg::*;
#(
  parameter int MAX_STEPS = 63
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [15:0]        cfg_step_size_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] start_joint1_i,
  input  wire logic signed [15:0] start_joint2_i,
  input  wire logic signed [15:0] start_joint3_i,
  input  wire logic signed [15:0] start_joint4_i,
  input  wire logic signed [15:0] end_joint1_i,
  input  wire logic signed [15:0] end_joint2_i,
  input  wire logic signed [15:0] end_joint3_i,
  input  wire logic signed [15:0] end_joint4_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      pose_joint1_o,
  output logic signed [15:0]      pose_joint2_o,
  output logic signed [15:0]      pose_joint3_o,
  output logic signed [15:0]      pose_joint4_o,
  output logic [5:0]              pose_index_o,
  output logic                    last_pose_o
);

  logic [NumJoints-1:0][AngleW-1:0] start_pose;
  logic [NumJoints-1:0][AngleW-1:0] end_pose;
  logic [NumJoints-1:0][AngleW-1:0] pose;

  logic       front_valid;
  logic       front_ready;
  mapi_desc_t front_desc;
  logic       back_valid;
  logic       back_ready;
  mapi_desc_t back_desc;

  assign start_pose = {start_joint4_i, start_joint3_i, start_joint2_i, start_joint1_i};
  assign end_pose   = {end_joint4_i, end_joint3_i, end_joint2_i, end_joint1_i};

  assign pose_joint1_o = pose[0];
  assign pose_joint2_o = pose[1];
  assign pose_joint3_o = pose[2];
  assign pose_joint4_o = pose[3];

  mapi_front #(
    .MAX_STEPS(MAX_STEPS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_step_size_i(cfg_step_size_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .start_i        (start_pose),
    .end_i          (end_pose),
    .desc_valid_o   (front_valid),
    .desc_ready_i   (front_ready),
    .desc_o         (front_desc)
  );

  mapi_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(front_valid),
    .wr_ready_o(front_ready),
    .wr_data_i (front_desc),
    .rd_valid_o(back_valid),
    .rd_ready_i(back_ready),
    .rd_data_o (back_desc)
  );

  mapi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .desc_valid_i(back_valid),
    .desc_ready_o(back_ready),
    .desc_i      (back_desc),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pose_o      (pose),
    .pose_index_o(pose_index_o),
    .last_pose_o (last_pose_o)
  );

endmodule

`default_nettype wire

/* sv/mapi_checker.sv */
// port-level checks on the pose interpolator, bound to the top level
// depends on multi_axis_pose_interpolator
`default_nettype none

module mapi_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [5:0] pose_index_o,
  input wire logic       last_pose_o
);

  logic [5:0] exp_idx_q;
  logic       out_acc;

  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_idx_q <= '0;
    end else if (out_acc) begin
      exp_idx_q <= last_pose_o ? 6'd0 : pose_index_o + 6'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pose_index_o))
    else $error("output request dropped or changed while stalled");

  a_index_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pose_index_o == exp_idx_q)
    else $error("pose index out of sequence");

  a_last_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_pose_o |-> pose_index_o != 6'd0)
    else $error("run ended on its first pose");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled while planning a request");

endmodule

bind multi_axis_pose_interpolator mapi_checker u_mapi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .pose_index_o(pose_index_o),
  .last_pose_o (last_pose_o)
);

`default_nettype wire
